@@ sv/svt_pkg.sv @@
// Package with the shared types and codes of the sorted value table.
`default_nettype none

package svt_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_RD,
    S_DEL_CMP,
    S_FIN_LO,
    S_FIN_HI,
    S_FIN_CAP,
    S_OUTPUT
  } ctl_state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_FULL,
    DP_INS_READ,
    DP_INS_SHIFT,
    DP_INS_PLACE,
    DP_DEL_READ,
    DP_DEL_STEP,
    DP_DEL_END,
    DP_RD_LO,
    DP_RD_HI,
    DP_CAP_HI,
    DP_OUT
  } dp_cmd_t;

  typedef struct packed {
    logic op_del;
    logic full;
    logic idx_zero;
    logic idx_at_count;
    logic shift_up;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/svt_req_if.sv @@
// Request channel: one insert or delete transaction per handshake.
`default_nettype none

interface svt_req_if;
  import svt_pkg::*;

  logic               valid;
  logic               ready;
  opcode_t            opcode;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

@@ sv/svt_rsp_if.sv @@
// Response channel: status, count and extreme values after each transaction.
`default_nettype none

interface svt_rsp_if;
  import svt_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [4:0]         entry_count;
  logic signed [31:0] smallest;
  logic signed [31:0] largest;

  modport source (output valid, output status, output entry_count, output smallest,
                  output largest, input ready);
  modport sink (input valid, input status, input entry_count, input smallest,
                input largest, output ready);
endinterface

`default_nettype wire

@@ sv/svt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module svt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/svt_ctrl.sv @@
// Controller state machine that sequences insert, delete and result steps.
`default_nettype none

module svt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire svt_pkg::dp_stat_t stat,
  output svt_pkg::dp_cmd_t      cmd
);
  import svt_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.op_del) state_next = S_DEL_RD;
        else if (stat.full) state_next = S_FIN_LO;
        else state_next = S_INS_RD;
      end
      S_INS_RD: begin
        state_next = stat.idx_zero ? S_FIN_LO : S_INS_CMP;
      end
      S_INS_CMP: begin
        state_next = stat.shift_up ? S_INS_RD : S_FIN_LO;
      end
      S_DEL_RD: begin
        state_next = stat.idx_at_count ? S_FIN_LO : S_DEL_CMP;
      end
      S_DEL_CMP: state_next = S_DEL_RD;
      S_FIN_LO:  state_next = S_FIN_HI;
      S_FIN_HI:  state_next = S_FIN_CAP;
      S_FIN_CAP: state_next = S_OUTPUT;
      S_OUTPUT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = DP_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = DP_LOAD;
      end
      S_DECIDE: begin
        if (!stat.op_del && stat.full) cmd = DP_FULL;
      end
      S_INS_RD: begin
        cmd = stat.idx_zero ? DP_INS_PLACE : DP_INS_READ;
      end
      S_INS_CMP: begin
        cmd = stat.shift_up ? DP_INS_SHIFT : DP_INS_PLACE;
      end
      S_DEL_RD: begin
        cmd = stat.idx_at_count ? DP_DEL_END : DP_DEL_READ;
      end
      S_DEL_CMP: cmd = DP_DEL_STEP;
      S_FIN_LO:  cmd = DP_RD_LO;
      S_FIN_HI:  cmd = DP_RD_HI;
      S_FIN_CAP: cmd = DP_CAP_HI;
      S_OUTPUT: begin
        if (stat.out_free) cmd = DP_OUT;
      end
      default: cmd = DP_NONE;
    endcase
  end

  // Every transaction walks through several states, so two never arrive on successive edges.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken on two successive cycles");

  // A result is loaded only from the output state.
  a_out_from_output: assert property (@(posedge clk) disable iff (rst)
    (cmd == DP_OUT) |-> (state == S_OUTPUT && stat.out_free))
    else $error("result loaded outside the output state");

endmodule

`default_nettype wire

@@ sv/svt_dp.sv @@
// Datapath: value store, scan index, count and the response register.
`default_nettype none

module svt_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire svt_pkg::dp_cmd_t   cmd,
  output svt_pkg::dp_stat_t       stat,
  input  wire svt_pkg::opcode_t   in_opcode,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output svt_pkg::status_t        out_status,
  output logic [4:0]              out_entry_count,
  output logic signed [31:0]      out_smallest,
  output logic signed [31:0]      out_largest
);
  import svt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  opcode_t            op;
  logic signed [31:0] val;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      count;
  logic               found;
  status_t            res_status;
  logic signed [31:0] lo;
  logic signed [31:0] hi;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] cnt_dec;
  logic          match;

  assign idx_dec = idx - CW'(1);
  assign cnt_dec = count - CW'(1);
  assign match   = (rdata == $unsigned(val));

  assign stat.op_del       = (op == OP_DELETE);
  assign stat.full         = (count == CW'(DEPTH));
  assign stat.idx_zero     = (idx == '0);
  assign stat.idx_at_count = (idx == count);
  assign stat.shift_up     = ($signed(rdata) >= val);
  assign stat.out_free     = !out_valid || out_ready;

  svt_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = $unsigned(val);
    raddr = '0;
    case (cmd)
      DP_INS_READ:  raddr = idx_dec[AW-1:0];
      DP_INS_SHIFT: begin
        we    = 1'b1;
        wdata = rdata;
      end
      DP_INS_PLACE: we = 1'b1;
      DP_DEL_READ:  raddr = idx[AW-1:0];
      DP_DEL_STEP: begin
        // Once the match is behind us, each later entry moves down by one.
        we    = found;
        waddr = idx_dec[AW-1:0];
        wdata = rdata;
      end
      DP_RD_LO:     raddr = '0;
      DP_RD_HI:     raddr = cnt_dec[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd == DP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        DP_INS_PLACE: count <= count + CW'(1);
        DP_DEL_END: begin
          if (found) count <= cnt_dec;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      DP_LOAD: begin
        op    <= in_opcode;
        val   <= in_value;
        found <= 1'b0;
        idx   <= (in_opcode == OP_INSERT) ? count : '0;
      end
      DP_FULL:      res_status <= ST_FULL;
      DP_INS_SHIFT: idx <= idx_dec;
      DP_INS_PLACE: res_status <= ST_INSERTED;
      DP_DEL_STEP: begin
        if (!found && match) found <= 1'b1;
        idx <= idx + CW'(1);
      end
      DP_DEL_END:   res_status <= found ? ST_DELETED : ST_NOT_FOUND;
      DP_RD_HI:     lo <= (count == '0) ? '0 : $signed(rdata);
      DP_CAP_HI:    hi <= (count == '0) ? '0 : $signed(rdata);
      DP_OUT: begin
        out_status      <= res_status;
        out_entry_count <= 5'(count);
        out_smallest    <= lo;
        out_largest     <= hi;
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("stored count above table depth");

  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    (cmd == DP_INS_PLACE) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not raise the count by one");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd != DP_INS_PLACE && cmd != DP_DEL_END) |=> $stable(count))
    else $error("count changed outside an insert or delete");

endmodule

`default_nettype wire

@@ sv/sorted_value_table.sv @@
// Sorted value table: keeps up to DEPTH signed values in ascending order.
//
// The req channel carries one transaction per handshake: opcode selects an
// insert or the deletion of one stored copy of value. The rsp channel returns
// exactly one transaction per request with the status, the new count and the
// smallest and largest stored values (both zero when the table is empty).
// An insert into a full table is dropped and reported as such.
//
// Requests are handled one at a time. The values live in a single-port-read
// RAM, and each scan step is a read state followed by a compare state with
// its write. An insert scans down from the top and moves each stored value
// not below the new one up by one before placing it; a delete scans every
// stored value and moves each one after the first match down by one, and an
// insert into a full table goes straight to reading the smallest and largest.
// After the response is loaded, the next request can be taken even while
// that response still waits; if the receiver stalls, the block holds the
// following result in its last state until the response register frees up.
// Synchronous reset empties the table and drops any pending response; the
// RAM needs no clearing pass because only entries below the count are read.
`default_nettype none

module sorted_value_table #(
  parameter int DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  svt_req_if.sink    req,
  svt_rsp_if.source  rsp
);
  import svt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign req.ready = in_ready;

  svt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  svt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (req.opcode),
    .in_value        (req.value),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_entry_count (rsp.entry_count),
    .out_smallest    (rsp.smallest),
    .out_largest     (rsp.largest)
  );

endmodule

`default_nettype wire

@@ bench/sorted_value_table_tb.sv @@
// Self-checking testbench for the sorted value table: directed and random inserts and deletes.
`default_nettype none

module sorted_value_table_tb;
  import svt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS = 150;
  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    status_t            status;
    logic [4:0]         entry_count;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
  } table_result_t;

  // Mirror of the table contents, plus the results still owed by the block.
  class table_scoreboard;
    logic signed [31:0] held_values[TABLE_DEPTH];
    int held_count = 0;
    table_result_t owed[$];
    int errors = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    function void note_request(opcode_t op, logic signed [31:0] v);
      table_result_t r;
      int pos;
      pos = 0;
      if (op == OP_INSERT) begin
        if (held_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          while (pos < held_count && held_values[pos] < v) pos++;
          for (int i = held_count; i > pos; i--) held_values[i] = held_values[i - 1];
          held_values[pos] = v;
          held_count++;
          r.status = ST_INSERTED;
        end
      end else begin
        while (pos < held_count && held_values[pos] != v) pos++;
        if (pos >= held_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < held_count; i++) held_values[i] = held_values[i + 1];
          held_count--;
          r.status = ST_DELETED;
        end
      end
      r.entry_count = held_count[4:0];
      r.smallest = (held_count == 0) ? 32'sd0 : held_values[0];
      r.largest = (held_count == 0) ? 32'sd0 : held_values[held_count - 1];
      owed.push_back(r);
    endfunction

    function void mismatch(string field, logic signed [31:0] want, logic signed [31:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: response transaction with no request outstanding, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status) mismatch("status", want.status, got.status);
      if (got.entry_count !== want.entry_count)
        mismatch("entry_count", want.entry_count, got.entry_count);
      if (got.smallest !== want.smallest) mismatch("smallest", want.smallest, got.smallest);
      if (got.largest !== want.largest) mismatch("largest", want.largest, got.largest);
    endfunction

    function logic signed [31:0] pick_stored();
      return held_values[$urandom_range(0, held_count - 1)];
    endfunction
  endclass

  logic clk;
  logic rst;
  svt_req_if req_ch ();
  svt_rsp_if rsp_ch ();
  table_scoreboard sb = new;

  bit hold_pending = 0;
  bit no_idling = 0;
  int stall_cycles = 0;

  sorted_value_table #(.DEPTH(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_INSERT;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;
  end

  // Both channels are observed at the rising edge; the watchdog counts edges without a
  // transaction on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.opcode, req_ch.value);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result({rsp_ch.status, rsp_ch.entry_count, rsp_ch.smallest, rsp_ch.largest});
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: bursts of back-pressure, and one long hold-off on request.
  initial begin
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        rsp_ch.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_pending = 0;
      end else if (!no_idling && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b1;
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end
    end
  end

  task automatic send_request(opcode_t op, logic signed [31:0] v);
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.opcode = op;
    req_ch.value = v;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    req_ch.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Small values give plenty of duplicates and delete hits; the rest toggle every bit.
  function automatic logic signed [31:0] pick_value();
    int near;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return VALUE_MIN;
          1: return VALUE_MAX;
          2: return -32'sd1;
          3: return 32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: begin
        near = $urandom_range(0, 16);
        return near - 8;
      end
    endcase
  endfunction

  initial begin
    int insert_odds[5] = '{85, 50, 20, 90, 45};
    bit sender_calm;
    opcode_t op;
    logic signed [31:0] v;

    @(negedge rst);

    // Directed: empty table, extremes, duplicates, a miss, filling up and a dropped insert.
    send_request(OP_DELETE, 32'sd7);
    send_request(OP_INSERT, VALUE_MAX);
    send_request(OP_INSERT, VALUE_MIN);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_DELETE, 32'sd99);
    for (int i = 0; i < 12; i++) send_request(OP_INSERT, (i % 3) * 1000 - 1000);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_DELETE, VALUE_MIN);
    send_request(OP_DELETE, VALUE_MAX);

    // Random phases alternate between filling and draining the table.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 1) hold_pending = 1;
      if (phase == 4) no_idling = 1;
      sender_calm = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) sender_calm = $urandom_range(0, 1);
        op = ($urandom_range(1, 100) <= insert_odds[phase]) ? OP_INSERT : OP_DELETE;
        if (op == OP_DELETE && sb.held_count > 0 && $urandom_range(0, 9) < 6)
          v = sb.pick_stored();
        else
          v = pick_value();
        send_request(op, v);
        if (!no_idling && !sender_calm && $urandom_range(0, 4) == 0)
          pause_sender($urandom_range(1, 17));
      end
    end
    pause_sender(1);

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d inserts, %0d deletes, %0d misses and %0d dropped inserts,",
             sb.status_seen[ST_INSERTED], sb.status_seen[ST_DELETED],
             sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL]);
    $display("with random back-pressure and one long receiver hold-off.");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
